// File: design/mexp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants, types and controller state for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned DataWidthDefault = 64;
  localparam logic [63:0] ModulusReset = 64'hFFFF_FFFF_0000_0001;
  localparam int unsigned FermatOffset = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXP_STEP,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } mexp_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture operands, start base reduction
    logic red_step;   // one bit of base reduction
    logic mul_start;  // start acc * base
    logic sqr_start;  // start base * base
    logic mm_step;    // one step of the modular multiplier
    logic mul_commit; // write product into accumulator
    logic sqr_commit; // write product into base
    logic exp_shift;  // drop exponent bit 0
    logic out_load;   // move accumulator to output register
  } mexp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic red_last;
    logic mm_last;
    logic exp_zero;
    logic exp_lsb;
  } mexp_status_t;

endpackage

`default_nettype wire

// File: design/mexp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_ctrl
// Sequencer for base reduction and right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
module mexp_ctrl
  import mexp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_fire,
  input  wire logic         out_busy,
  input  wire mexp_status_t sts,
  output mexp_cmd_t         cmd,
  output logic              in_stall
);

  mexp_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_fire) state_next = ST_REDUCE;
      ST_REDUCE:   if (sts.red_last) state_next = ST_EXP_STEP;
      ST_EXP_STEP: begin
        if (sts.exp_zero) state_next = ST_DONE;
        else if (sts.exp_lsb) state_next = ST_MUL;
        else state_next = ST_SQR;
      end
      ST_MUL:      if (sts.mm_last) state_next = ST_SQR;
      ST_SQR:      if (sts.mm_last) state_next = ST_EXP_STEP;
      ST_DONE:     if (!out_busy) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_fire;
      end
      ST_REDUCE: begin
        cmd.red_step = 1'b1;
      end
      ST_EXP_STEP: begin
        cmd.mul_start = !sts.exp_zero && sts.exp_lsb;
        cmd.sqr_start = !sts.exp_zero && !sts.exp_lsb;
      end
      ST_MUL: begin
        cmd.mm_step = 1'b1;
        cmd.mul_commit = sts.mm_last;
        cmd.sqr_start = sts.mm_last;
      end
      ST_SQR: begin
        cmd.mm_step = 1'b1;
        cmd.sqr_commit = sts.mm_last;
        cmd.exp_shift = sts.mm_last;
      end
      ST_DONE: begin
        cmd.out_load = !out_busy;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: design/mexp_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_dp
// Datapath: bitwise base reduction, interleaved shift-add modular multiplier,
// accumulator, base and exponent registers.
// ----------------------------------------------------------------------------
module mexp_dp
  import mexp_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  wire logic                  clk,
  input  wire logic [DATA_WIDTH-1:0] modulus,
  input  wire logic                  kind,
  input  wire logic [DATA_WIDTH-1:0] base_value,
  input  wire logic [DATA_WIDTH-1:0] exponent,
  input  wire mexp_cmd_t             cmd,
  output mexp_status_t               sts,
  output logic [DATA_WIDTH-1:0]      acc
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(DATA_WIDTH - 1);

  logic [DATA_WIDTH-1:0] p, base, expo, braw, mm_x, mm_y, mm_r;
  logic [CntW-1:0]       cnt;
  logic                  p_small;

  // doubled-plus-addend modular update: r = (2r + a) mod p, r < p
  function automatic logic [DATA_WIDTH-1:0] dbl_add(
    input logic [DATA_WIDTH-1:0] r, input logic [DATA_WIDTH-1:0] a,
    input logic [DATA_WIDTH-1:0] m);
    logic [DATA_WIDTH:0] s;
    logic [DATA_WIDTH+1:0] t;
    s = {r, 1'b0};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    t = {1'b0, s} + {2'b00, a};
    if (t >= {2'b00, m}) t = t - {2'b00, m};
    return t[DATA_WIDTH-1:0];
  endfunction

  logic [DATA_WIDTH-1:0] red_next, mm_next;
  assign red_next = dbl_add(base, {{(DATA_WIDTH-1){1'b0}}, braw[DATA_WIDTH-1]}, p);
  assign mm_next  = dbl_add(mm_r, mm_y[DATA_WIDTH-1] ? mm_x : '0, p);

  // registers; a modulus below two yields zero, so the accumulator starts there
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      p <= modulus;
      braw <= base_value;
      base <= '0;
      expo <= kind ? modulus - DATA_WIDTH'(FermatOffset) : exponent;
      acc <= (modulus < DATA_WIDTH'(2)) ? '0 : {{(DATA_WIDTH-1){1'b0}}, 1'b1};
      p_small <= (modulus < DATA_WIDTH'(2));
      cnt <= '0;
    end
    if (cmd.red_step) begin
      base <= red_next;
      braw <= braw << 1;
      cnt <= (cnt == CntLast) ? '0 : cnt + 1'b1;
      if (cnt == CntLast && p_small) expo <= '0;
    end
    if (cmd.mul_start) begin
      mm_x <= base; mm_y <= acc; mm_r <= '0; cnt <= '0;
    end
    if (cmd.sqr_start) begin
      mm_x <= base; mm_y <= base; mm_r <= '0; cnt <= '0;
    end
    // multiplier step, unless a square starts on the last step of a multiply
    if (cmd.mm_step && !cmd.sqr_start) begin
      mm_r <= mm_next;
      mm_y <= mm_y << 1;
      cnt <= (cnt == CntLast) ? '0 : cnt + 1'b1;
    end
    if (cmd.mul_commit) acc <= mm_next;
    if (cmd.sqr_commit) base <= mm_next;
    if (cmd.exp_shift) expo <= expo >> 1;
  end

  // status
  assign sts.red_last = (cnt == CntLast);
  assign sts.mm_last  = (cnt == CntLast);
  assign sts.exp_zero = (expo == '0);
  assign sts.exp_lsb  = expo[0];

endmodule

`default_nettype wire

// File: design/modular_exponentiation_64_top.sv
`default_nettype none
// Timing: base reduction first, then per exponent bit a square, preceded by a
//   multiply when the bit is set; the shared bit-serial multiplier sets the pace.
//   A zero exponent goes straight from the reduction to the result.
// Flow: one item in flight; a new item is accepted only once the result has
//   moved into the output register, which waits while the output is stalled.
// Reset: synchronous, active high; modulus returns to 2^64 - 2^32 + 1.
// ----------------------------------------------------------------------------
// modular_exponentiation_64_top
// base^exponent mod p, or Fermat inverse, with a configurable modulus.
// ----------------------------------------------------------------------------
module modular_exponentiation_64_top
  import mexp_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [63:0] modulus,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        kind,
  input  wire logic [63:0] base_value,
  input  wire logic [63:0] exponent,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      result
);

  logic [DATA_WIDTH-1:0] modulus_reg, acc;
  mexp_cmd_t             cmd;
  mexp_status_t          sts;
  logic                  in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && !in_stall;

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) modulus_reg <= ModulusReset[DATA_WIDTH-1:0];
    else if (cfg_valid) modulus_reg <= modulus[DATA_WIDTH-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) result <= 64'(acc);
  end

  mexp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .out_busy(out_valid && out_stall), .sts(sts), .cmd(cmd), .in_stall(in_stall)
  );

  mexp_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk(clk), .modulus(modulus_reg), .kind(kind),
    .base_value(base_value[DATA_WIDTH-1:0]), .exponent(exponent[DATA_WIDTH-1:0]),
    .cmd(cmd), .sts(sts), .acc(acc)
  );

endmodule

`default_nettype wire

// File: tb/tb_modular_exponentiation_64_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation_64_top
// Self-checking bench for the 64-bit modular exponentiation block. A short
// stimulus table hits the extremes and the special cases, then random beats
// run under a series of moduli. Typed rows are checked against the table
// value, others against a square-and-multiply predictor on 128-bit products.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_64_top
  import mexp_pkg::*;
;

  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Prime64Max = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam longint unsigned CycleLimit = 40_000_000;
  localparam int RandPerPhase = 64;
  localparam int NumPhases = 9;
  localparam logic KindPow = 1'b0;
  localparam logic KindInv = 1'b1;

  typedef struct {
    logic        kind;
    logic [63:0] base;
    logic [63:0] expo;
    bit          typed;
    logic [63:0] want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] modulus = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [63:0] base_value = '0;
  logic [63:0] exponent = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] result;

  logic [63:0]     cur_modulus;
  logic [63:0]     pending_results[$];
  int              mismatches = 0;
  int              beats_sent = 0;
  int              beats_checked = 0;
  int              inverse_beats = 0;
  int              burst_left = 0;
  longint unsigned cycles = 0;

  stim_row_t  rows[$];
  logic [63:0] phase_mod[NumPhases];

  modular_exponentiation_64_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .modulus    (modulus),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .base_value (base_value),
    .exponent   (exponent),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  // clock
  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // square-and-multiply with exact double-width remainders
  function automatic logic [63:0] modpow_predict(logic k, logic [63:0] b, logic [63:0] e,
                                                 logic [63:0] p);
    logic [127:0] prod;
    logic [63:0]  acc;
    logic [63:0]  sq;
    logic [63:0]  ee;
    if (p < 2) return '0;
    ee = k ? p - FermatOffset : e;
    acc = 64'd1;
    sq = b % p;
    while (ee != 0) begin
      if (ee[0]) begin
        prod = {64'd0, acc} * {64'd0, sq};
        acc = 64'(prod % {64'd0, p});
      end
      prod = {64'd0, sq} * {64'd0, sq};
      sq = 64'(prod % {64'd0, p});
      ee = ee >> 1;
    end
    return acc;
  endfunction

  // receiver: stall pattern with calm stretches, check each result beat
  int stall_mode = 0;
  int mode_left = 0;
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", result);
      end else begin
        want = pending_results.pop_front();
        beats_checked++;
        if (result !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h actual %h", want, result);
        end
      end
    end
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(50, 4000);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // one input beat, with burst and gap pacing
  task automatic send_beat(logic k, logic [63:0] b, logic [63:0] e);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    kind <= k;
    base_value <= b;
    exponent <= e;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(modpow_predict(k, b, e, cur_modulus));
    beats_sent++;
    if (k) inverse_beats++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // modulus write, only with the block idle
  task automatic write_modulus(logic [63:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    modulus <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_modulus = v;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // exponent of random bit length, mostly short to keep runs quick
  function automatic logic [63:0] rand_expo();
    int nbits;
    logic [63:0] v;
    nbits = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(0, 20);
    v = rand64();
    if (nbits == 0) return '0;
    if (nbits < 64) v = v & ((64'd1 << nbits) - 1);
    return v;
  endfunction

  // operand near the interesting corners or fully random
  function automatic logic [63:0] rand_base(logic [63:0] p);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 64'd1;
      2: return p - 1;
      3: return p;
      4: return AllOnes;
      default: return rand64();
    endcase
  endfunction

  initial begin
    stim_row_t r;
    logic [63:0] got_want;
    logic k;
    cur_modulus = ModulusReset;

    // table: kind, base, exponent, typed, expected
    rows.push_back('{KindPow, 64'd0, 64'd0, 1, 64'd1});
    rows.push_back('{KindPow, 64'd123, 64'd0, 1, 64'd1});
    rows.push_back('{KindPow, 64'd0, 64'd5, 1, 64'd0});
    rows.push_back('{KindPow, AllOnes, 64'd1, 1, 64'h0000_0000_FFFF_FFFE});
    rows.push_back('{KindPow, 64'd2, 64'd1, 1, 64'd2});
    rows.push_back('{KindPow, ModulusReset, 64'd7, 1, 64'd0});
    rows.push_back('{KindPow, ModulusReset - 1, 64'd2, 1, 64'd1});
    rows.push_back('{KindInv, 64'd0, 64'd9, 1, 64'd0});
    rows.push_back('{KindInv, 64'd1, AllOnes, 1, 64'd1});
    rows.push_back('{KindInv, ModulusReset - 1, 64'd0, 1, ModulusReset - 1});
    rows.push_back('{KindPow, AllOnes, AllOnes, 0, 64'd0});
    rows.push_back('{KindInv, AllOnes, AllOnes, 0, 64'd0});
    rows.push_back('{KindPow, 64'd3, 64'h8000_0000_0000_0000, 0, 64'd0});
    rows.push_back('{KindPow, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 0, 64'd0});
    rows.push_back('{KindPow, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, 64'd0});
    rows.push_back('{KindInv, 64'd7, 64'd0, 0, 64'd0});

    phase_mod[0] = ModulusReset;
    phase_mod[1] = 64'd2;
    phase_mod[2] = 64'd0;
    phase_mod[3] = 64'd1;
    phase_mod[4] = 64'd3;
    phase_mod[5] = Prime64Max;
    phase_mod[6] = AllOnes;
    phase_mod[7] = 64'd97;
    phase_mod[8] = rand64() | 64'd2;

    // reset
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows under the reset modulus
    foreach (rows[i]) begin
      r = rows[i];
      send_beat(r.kind, r.base, r.expo);
      if (r.typed) begin
        got_want = pending_results[$];
        if (got_want !== r.want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: predictor %h, table %h", i, got_want, r.want);
        end
        pending_results[$] = r.want;
      end
    end

    // random phases, one modulus each; p = 2 also covers inverse of zero
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_modulus(phase_mod[ph]);
      if (phase_mod[ph] == 64'd2) send_beat(KindInv, 64'd0, rand64());
      for (int n = 0; n < RandPerPhase; n++) begin
        k = ($urandom_range(0, 7) == 0);
        send_beat(k, rand_base(phase_mod[ph]), rand_expo());
        if (n == RandPerPhase / 2) drain_results();
      end
    end

    // wait for the tail, then a little extra
    drain_results();
    repeat (200) @(posedge clk);
    $display("%0d beats in, %0d results checked (%0d inverse), %0d moduli",
             beats_sent, beats_checked, inverse_beats, NumPhases);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
design/mexp_pkg.sv
design/mexp_ctrl.sv
design/mexp_dp.sv
design/modular_exponentiation_64_top.sv
tb/tb_modular_exponentiation_64_top.sv
